### rtl/carreau_viscosity_from_gradient_top_defines.svh
// Assertion macros shared by the checker of the Carreau viscosity block.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef CARREAU_VISCOSITY_FROM_GRADIENT_TOP_DEFINES_SVH
`define CARREAU_VISCOSITY_FROM_GRADIENT_TOP_DEFINES_SVH

// Check a property outside reset.
`define CVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define CVG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/cvg_pkg.sv
// Shared types, constants and root table function for the Carreau viscosity block.
// No dependencies.
package cvg_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned LOG_FRAC   = 20;
  localparam int unsigned EXP_FRAC   = 20;

  localparam logic [1:0] DIMS_2D = 2'd2;

  typedef enum logic [1:0] {
    CFG_DIMS = 2'd0,
    CFG_A    = 2'd1,
    CFG_B    = 2'd2,
    CFG_C    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] g00;
    logic signed [31:0] g01;
    logic signed [31:0] g02;
    logic signed [31:0] g10;
    logic signed [31:0] g11;
    logic signed [31:0] g12;
    logic signed [31:0] g20;
    logic signed [31:0] g21;
    logic signed [31:0] g22;
  } in_t;

  typedef struct packed {
    logic [31:0] shear_rate;
    logic [31:0] viscosity;
    logic        saturated;
  } out_t;

  // Magnitudes of the diagonal terms and of the symmetric off-diagonal sums.
  typedef struct packed {
    logic [2:0][31:0] dabs;
    logic [2:0][32:0] pabs;
    logic             ovf;
  } front_t;

  typedef struct packed {
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] exponent_c;
  } coef_t;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-j) in Q0.32, by repeated floor square roots.
  function automatic logic [31:0] root_at(input int j);
    logic [63:0] r;
    r = isqrt_c(64'h8000_0000_0000_0000);
    for (int i = 2; i <= EXP_FRAC; i++) begin
      if (i <= j) begin
        r = isqrt_c({r[31:0], 32'h0});
      end
    end
    return r[31:0];
  endfunction

endpackage

### rtl/carreau_viscosity_from_gradient_top.sv
// Carreau viscosity from a velocity gradient; a front register, a queue and
// the back pipeline lie between input transfer and output valid. Throughput
// one matrix per cycle unless the output stalls; the 32-stage square root,
// the 20 log2 squaring and 20 exp2 root-table stages are fully pipelined.
// Reset clears all valid flags and loads dimensions 3, a = b = c = 1.0.
module carreau_viscosity_from_gradient_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cvg_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cvg_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  logic [1:0]      dims_q;
  cvg_pkg::coef_t  coef_q;
  logic            f_valid;
  logic            f_ready;
  cvg_pkg::front_t f_data;
  logic            q_valid;
  logic            q_ready;
  cvg_pkg::front_t q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q            <= 2'd3;
      coef_q.coef_a     <= 32'h0001_0000;
      coef_q.coef_b     <= 32'h0001_0000;
      coef_q.exponent_c <= 32'h0001_0000;
    end else if (cfg_valid_i) begin
      case (cvg_pkg::cfg_idx_e'(cfg_index_i))
        cvg_pkg::CFG_DIMS: dims_q            <= cfg_data_i[1:0];
        cvg_pkg::CFG_A:    coef_q.coef_a     <= cfg_data_i;
        cvg_pkg::CFG_B:    coef_q.coef_b     <= cfg_data_i;
        cvg_pkg::CFG_C:    coef_q.exponent_c <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cvg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  cvg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  cvg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/cvg_front.sv
// Front stage: takes gradient matrices, forms term magnitudes and the overflow flag.
// Depends on cvg_pkg.
module cvg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      dims_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cvg_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cvg_pkg::front_t out_data_o
);

  logic            valid_q;
  cvg_pkg::front_t data_q;
  cvg_pkg::front_t data_d;

  function automatic logic [31:0] diag_abs(input logic signed [31:0] g);
    logic [32:0] w;
    w = {g[31], g};
    return w[32] ? 32'(~w + 33'd1) : w[31:0];
  endfunction

  function automatic logic [32:0] pair_abs(input logic signed [31:0] g,
                                           input logic signed [31:0] h);
    logic [32:0] s;
    s = {g[31], g} + {h[31], h};
    return s[32] ? (~s + 33'd1) : s;
  endfunction

  always_comb begin
    logic two_d;
    two_d = (dims_i == cvg_pkg::DIMS_2D);
    data_d.dabs[0] = diag_abs(in_data_i.g00);
    data_d.dabs[1] = diag_abs(in_data_i.g11);
    data_d.dabs[2] = two_d ? 32'h0 : diag_abs(in_data_i.g22);
    data_d.pabs[0] = pair_abs(in_data_i.g01, in_data_i.g10);
    data_d.pabs[1] = two_d ? 33'h0 : pair_abs(in_data_i.g02, in_data_i.g20);
    data_d.pabs[2] = two_d ? 33'h0 : pair_abs(in_data_i.g12, in_data_i.g21);
    // a symmetric sum of magnitude 2^32 does not fit the 64-bit square
    data_d.ovf = data_d.pabs[0][32] | data_d.pabs[1][32] | data_d.pabs[2][32];
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### rtl/cvg_fifo.sv
// Two-entry queue between front and back stages.
// Depends on cvg_pkg.
module cvg_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  cvg_pkg::front_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output cvg_pkg::front_t pop_data_o
);

  cvg_pkg::front_t mem_q [0:1];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/cvg_back.sv
// Back pipeline: squares, square root, log2, exponent product, exp2 and scaling.
// Depends on cvg_pkg; the whole pipeline holds while the output waits.
module cvg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cvg_pkg::coef_t  coef_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cvg_pkg::front_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cvg_pkg::out_t   out_data_o
);

  localparam int unsigned NSTG   = 81;
  localparam int unsigned ST_BM  = 34;
  localparam int unsigned ST_OUT = 80;
  localparam int unsigned LF     = cvg_pkg::LOG_FRAC;
  localparam int unsigned EF     = cvg_pkg::EXP_FRAC;
  localparam int unsigned FB     = cvg_pkg::FRAC_BITS;

  logic en;
  logic vld_q [0:NSTG-1];
  logic ovf_q [0:ST_OUT-1];
  logic [31:0] shr_q [ST_BM:ST_OUT-1];

  // advance only when the output register is free or taken
  assign en = !vld_q[ST_OUT] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // squares
  logic [2:0][63:0] sqd_q;
  logic [2:0][65:0] sqp_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sqd_q[k] <= 64'(in_data_i.dabs[k]) * 64'(in_data_i.dabs[k]);
        sqp_q[k] <= 66'(in_data_i.pabs[k]) * 66'(in_data_i.pabs[k]);
      end
      ovf_q[0] <= in_data_i.ovf;
    end
  end

  // sum, then square root one result bit per stage
  logic [63:0] sqv_q [0:32];
  logic [35:0] rem_q [0:32];
  logic [31:0] rt_q  [0:32];
  logic [67:0] sum;
  assign sum = {3'b0, sqd_q[0], 1'b0} + {3'b0, sqd_q[1], 1'b0} + {3'b0, sqd_q[2], 1'b0}
             + {2'b0, sqp_q[0]} + {2'b0, sqp_q[1]} + {2'b0, sqp_q[2]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqv_q[0] <= sum[63:0];
      rem_q[0] <= '0;
      rt_q[0]  <= '0;
      ovf_q[1] <= ovf_q[0] | (sum[67:64] != 4'h0);
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_sqrt
    logic [35:0] rsh;
    logic [35:0] trial;
    logic        ge;
    assign rsh   = {rem_q[i][33:0], sqv_q[i][63:62]};
    assign trial = {2'b0, rt_q[i], 2'b01};
    assign ge    = (rsh >= trial);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqv_q[i+1] <= {sqv_q[i][61:0], 2'b00};
        rem_q[i+1] <= ge ? rsh - trial : rsh;
        rt_q[i+1]  <= {rt_q[i][30:0], ge};
      end
    end
  end

  for (genvar k = 2; k < ST_OUT; k++) begin : g_ovf
    always_ff @(posedge clk_i) begin
      if (en) ovf_q[k] <= ovf_q[k-1];
    end
  end

  // b * S, then X = 1 + b*S in Q33.16, then locate its leading one
  logic [63:0] bx_q;
  logic [48:0] x_q;
  logic [48:0] x2_q;
  logic [5:0]  msb_q;
  logic [5:0]  msb_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      shr_q[ST_BM] <= ovf_q[ST_BM-1] ? 32'hFFFF_FFFF : rt_q[32];
      bx_q <= 64'(coef_i.coef_b) *
              64'(ovf_q[ST_BM-1] ? 32'hFFFF_FFFF : rt_q[32]);
    end
  end

  for (genvar k = ST_BM + 1; k < ST_OUT; k++) begin : g_shr
    always_ff @(posedge clk_i) begin
      if (en) shr_q[k] <= shr_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) x_q <= {1'b0, bx_q[63:FB]} + (49'd1 << FB);
  end

  always_comb begin
    msb_d = 6'(FB);
    for (int i = 0; i < 49; i++) begin
      if (x_q[i]) msb_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      msb_q <= msb_d;
      x2_q  <= x_q;
    end
  end

  // log2: mantissa into Q1.31, then one fraction bit per squaring stage
  logic [31:0]   lm_q [0:LF];
  logic [LF-1:0] fr_q [0:LF];
  logic [5:0]    lk_q [0:LF];
  logic [48:0]   mn;
  assign mn = (msb_q >= 6'd31) ? (x2_q >> (msb_q - 6'd31)) : (x2_q << (6'd31 - msb_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      lm_q[0] <= mn[31:0];
      fr_q[0] <= '0;
      lk_q[0] <= msb_q - 6'(FB);
    end
  end

  for (genvar i = 0; i < LF; i++) begin : g_log
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(lm_q[i]) * 64'(lm_q[i]);
    assign t  = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en) begin
        lm_q[i+1] <= t[32] ? t[32:1] : t[31:0];
        fr_q[i+1] <= {fr_q[i][LF-2:0], t[32]};
        lk_q[i+1] <= lk_q[i];
      end
    end
  end

  // E = c * log2(X); exp2 of the negated fraction through the root table
  logic [57:0]   e;
  logic [32:0]   pp_q  [0:EF];
  logic [EF-1:0] pef_q [0:EF];
  logic [21:0]   pei_q [0:EF];
  assign e = 58'(coef_i.exponent_c) * 58'({lk_q[LF], fr_q[LF]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q[0]  <= 33'h1_0000_0000;
      pef_q[0] <= e[FB+LF-1 -: EF];
      pei_q[0] <= e[57:FB+LF];
    end
  end

  for (genvar j = 1; j <= EF; j++) begin : g_pow
    localparam logic [31:0] ROOT = cvg_pkg::root_at(j);
    logic [64:0] prod;
    assign prod = 65'(pp_q[j-1]) * 65'(ROOT);
    always_ff @(posedge clk_i) begin
      if (en) begin
        pp_q[j]  <= pef_q[j-1][EF-j] ? prod[64:32] : pp_q[j-1];
        pef_q[j] <= pef_q[j-1];
        pei_q[j] <= pei_q[j-1];
      end
    end
  end

  // a * P, then shift by 32 + integer part of E
  logic [64:0] ap_q;
  logic [21:0] aei_q;
  logic [32:0] aph;
  logic [31:0] visc;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ap_q  <= 65'(coef_i.coef_a) * 65'(pp_q[EF]);
      aei_q <= pei_q[EF];
    end
  end

  assign aph  = ap_q[64:32] >> aei_q[4:0];
  assign visc = (aei_q[21:5] == 17'h0) ? aph[31:0] : 32'h0;

  cvg_pkg::out_t out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.shear_rate <= shr_q[ST_OUT-1];
      out_q.viscosity  <= visc;
      out_q.saturated  <= ovf_q[ST_OUT-1];
    end
  end

  assign out_valid_o = vld_q[ST_OUT];
  assign out_data_o  = out_q;

endmodule

### rtl/cvg_checker.sv
// Port-level checks for the Carreau viscosity block, bound to the top level.
// Depends on cvg_pkg and the assertion macro header.
`include "carreau_viscosity_from_gradient_top_defines.svh"

module cvg_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cvg_pkg::out_t out_data_o,
  input logic          cfg_ready_o
);

  `CVG_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid during reset")

  `CVG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled output changed")

  `CVG_ASSERT(a_sat_all_ones, out_valid_o && out_data_o.saturated |-> out_data_o.shear_rate == 32'hFFFF_FFFF, "saturated shear rate not clipped")

  `CVG_ASSERT(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

bind carreau_viscosity_from_gradient_top cvg_checker u_cvg_checker (.*);
